/* rtl/core/quaternion_multiply_inverse_core_defines.svh */
// Assertion macros for the quaternion multiply / inverse core checkers
`ifndef QUATERNION_MULTIPLY_INVERSE_CORE_DEFINES_SVH
`define QUATERNION_MULTIPLY_INVERSE_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define QMI_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define QMI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/qmi_pkg.sv */
// Shared constants and types for the quaternion multiply / inverse core
`default_nettype none
package qmi_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 24;
  // quotient bits kept by the divider: anything at or above 2^33 saturates
  localparam int QBITS         = 33;
  // squared norm of four 32-bit components needs up to 65 bits
  localparam int NORM_W        = 65;
  // exact sum of four signed 64-bit products
  localparam int SUM_W         = 66;

  typedef enum logic {
    OP_MUL = 1'b0,
    OP_INV = 1'b1
  } qmi_op_t;

  // one divider stage: partial remainder and shifting numerator/quotient per lane
  typedef struct packed {
    logic [3:0][NORM_W-1:0] rem;
    logic [3:0][QBITS-1:0]  nq;
    logic [NORM_W-1:0]      norm;
  } qmi_div_t;

endpackage
`default_nettype wire

/* rtl/core/qmi_div_pipe.sv */
// Four-lane restoring divider, one quotient bit per pipeline stage
`default_nettype none
module qmi_div_pipe (
  input  logic                                  clk,
  input  logic                                  en,
  input  qmi_pkg::qmi_div_t                     div_i,
  output logic [3:0][qmi_pkg::QBITS-1:0]        q_o
);

  localparam int QB = qmi_pkg::QBITS;
  localparam int NW = qmi_pkg::NORM_W;

  qmi_pkg::qmi_div_t stage_r   [QB];
  qmi_pkg::qmi_div_t stage_nxt [QB];

  genvar k;
  generate
    for (k = 0; k < QB; k++) begin : g_stage
      qmi_pkg::qmi_div_t src;
      if (k == 0) begin : g_first
        assign src = div_i;
      end else begin : g_rest
        assign src = stage_r[k-1];
      end

      // bring down one numerator bit, subtract the norm where it fits
      always_comb begin
        logic [NW:0] t;
        logic        ge;
        stage_nxt[k].norm = src.norm;
        for (int l = 0; l < 4; l++) begin
          t  = {src.rem[l], src.nq[l][QB-1]};
          ge = (t >= {1'b0, src.norm});
          stage_nxt[k].rem[l] = ge ? NW'(t - {1'b0, src.norm}) : NW'(t);
          stage_nxt[k].nq[l]  = {src.nq[l][QB-2:0], ge};
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          stage_r[k] <= stage_nxt[k];
        end
      end
    end
  endgenerate

  assign q_o = stage_r[QB-1].nq;

endmodule
`default_nettype wire

/* rtl/core/quaternion_multiply_inverse_core.sv */
// Top level of the quaternion Hamilton product / inverse unit
// Usage:
//   Input channel in_valid/in_ready carries in_opcode and quaternions A, B
//   (signed fixed point, FRAC_BITS fraction bits). Opcode multiply returns
//   A*B rounded to nearest (ties up); opcode inverse returns conj(A)/|A|^2
//   rounded to nearest (ties away from zero). B is ignored for inverse.
//   Result channel out_valid/out_ready carries res_w..res_z, saturated, plus
//   the saturated and zero_norm flags. An all-zero A under inverse returns
//   zeros with zero_norm set.
//   Pipeline: four stages of multiply / sum / scale, 33 stages of the divider
//   (one quotient bit each), one output register. Multiply items take the
//   same path length so order is kept.
//   Throughput: one item per cycle while out_ready is high.
//   A stalled result holds the whole pipeline; in_ready drops only while
//   the output register is full and out_ready is low. No item is lost.
//   Reset clears all valid bits; the pipeline comes up empty.
`default_nettype none
module quaternion_multiply_inverse_core #(
  parameter int FRAC_BITS = qmi_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_opcode,
  input  logic signed [31:0] in_a_w,
  input  logic signed [31:0] in_a_x,
  input  logic signed [31:0] in_a_y,
  input  logic signed [31:0] in_a_z,
  input  logic signed [31:0] in_b_w,
  input  logic signed [31:0] in_b_x,
  input  logic signed [31:0] in_b_y,
  input  logic signed [31:0] in_b_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_res_w,
  output logic signed [31:0] out_res_x,
  output logic signed [31:0] out_res_y,
  output logic signed [31:0] out_res_z,
  output logic               out_saturated,
  output logic               out_zero_norm
);

  localparam int DW    = qmi_pkg::DATA_W;
  localparam int QB    = qmi_pkg::QBITS;
  localparam int NW    = qmi_pkg::NORM_W;
  localparam int SW    = qmi_pkg::SUM_W;
  localparam int NS    = QB + 5;
  localparam int SH    = 2 * FRAC_BITS + 1;
  localparam int CMP_W = NW + QB + 1;

  localparam logic signed [SW-1:0] HALF   = SW'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SW-1:0] SAT_HI = SW'(64'sh7FFF_FFFF);
  localparam logic signed [SW-1:0] SAT_LO = -SAT_HI - SW'(1);
  localparam logic [DW-1:0]        MAXV   = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0]        MINV   = {1'b1, {(DW-1){1'b0}}};
  localparam logic [QB-1:0]        HALF_Q = QB'(MINV);

  typedef struct packed {
    qmi_pkg::qmi_op_t       op;
    logic                   zn;
    logic [3:0]             ovf;
    logic [3:0]             neg;
    logic [3:0][DW-1:0]     res;
    logic                   sat;
  } qmi_side_t;

  // pipeline control: everything moves when the output register can empty
  logic [NS-1:0] v_r;
  logic          en;

  assign en       = !v_r[NS-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NS-2:0], in_valid};
    end
  end

  // stage 1: input register
  qmi_pkg::qmi_op_t   op_s1_r;
  logic signed [DW-1:0] a_s1_r [4];
  logic signed [DW-1:0] b_s1_r [4];

  always_ff @(posedge clk) begin
    if (en) begin
      op_s1_r   <= qmi_pkg::qmi_op_t'(in_opcode);
      a_s1_r[0] <= in_a_w;
      a_s1_r[1] <= in_a_x;
      a_s1_r[2] <= in_a_y;
      a_s1_r[3] <= in_a_z;
      b_s1_r[0] <= in_b_w;
      b_s1_r[1] <= in_b_x;
      b_s1_r[2] <= in_b_y;
      b_s1_r[3] <= in_b_z;
    end
  end

  // stage 2: 16 products a_i * b_j; under inverse B is replaced by A so the
  // diagonal gives the squares
  qmi_pkg::qmi_op_t     op_s2_r;
  logic signed [63:0]   prod_s2_r [4][4];
  logic [DW-1:0]        mag_s2_r  [4];
  logic [3:0]           neg_s2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      op_s2_r <= op_s1_r;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          prod_s2_r[i][j] <= a_s1_r[i] *
                             ((op_s1_r == qmi_pkg::OP_INV) ? a_s1_r[j] : b_s1_r[j]);
        end
        mag_s2_r[i] <= a_s1_r[i][DW-1] ? (~a_s1_r[i] + DW'(1)) : a_s1_r[i];
      end
      // sign of the conjugate component: w keeps it, x/y/z flip it
      neg_s2_r[0] <= a_s1_r[0][DW-1];
      for (int i = 1; i < 4; i++) begin
        neg_s2_r[i] <= !a_s1_r[i][DW-1] && (a_s1_r[i] != '0);
      end
    end
  end

  // stage 3: Hamilton sums rounded, or the squared norm
  logic signed [SW-1:0] sum_c [4];
  logic signed [SW-1:0] p_c   [4][4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p_c[i][j] = SW'(prod_s2_r[i][j]);
      end
    end
    sum_c[0] = p_c[0][0] - p_c[1][1] - p_c[2][2] - p_c[3][3];
    sum_c[1] = p_c[0][1] + p_c[1][0] + p_c[2][3] - p_c[3][2];
    sum_c[2] = p_c[0][2] + p_c[2][0] - p_c[1][3] + p_c[3][1];
    sum_c[3] = p_c[0][3] + p_c[3][0] + p_c[1][2] - p_c[2][1];
  end

  qmi_pkg::qmi_op_t     op_s3_r;
  logic signed [SW-1:0] rnd_s3_r [4];
  logic [NW-1:0]        norm_s3_r;
  logic [DW-1:0]        mag_s3_r [4];
  logic [3:0]           neg_s3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      op_s3_r  <= op_s2_r;
      neg_s3_r <= neg_s2_r;
      for (int i = 0; i < 4; i++) begin
        rnd_s3_r[i] <= (sum_c[i] + HALF) >>> FRAC_BITS;
        mag_s3_r[i] <= mag_s2_r[i];
      end
      norm_s3_r <= {1'b0, prod_s2_r[0][0]} + {1'b0, prod_s2_r[1][1]} +
                   {1'b0, prod_s2_r[2][2]} + {1'b0, prod_s2_r[3][3]};
    end
  end

  // stage 4: saturate the product; set up the division
  qmi_side_t         side_nxt;
  qmi_pkg::qmi_div_t div_nxt;

  always_comb begin
    logic [CMP_W-1:0] num;
    logic [CMP_W-1:0] lim;
    side_nxt.op  = op_s3_r;
    side_nxt.zn  = (op_s3_r == qmi_pkg::OP_INV) && (norm_s3_r == '0);
    side_nxt.neg = neg_s3_r;
    side_nxt.sat = 1'b0;
    div_nxt.norm = norm_s3_r;
    lim = CMP_W'(norm_s3_r) << QB;
    for (int i = 0; i < 4; i++) begin
      if (rnd_s3_r[i] > SAT_HI) begin
        side_nxt.res[i] = MAXV;
        side_nxt.sat    = 1'b1;
      end else if (rnd_s3_r[i] < SAT_LO) begin
        side_nxt.res[i] = MINV;
        side_nxt.sat    = 1'b1;
      end else begin
        side_nxt.res[i] = rnd_s3_r[i][DW-1:0];
      end
      num = CMP_W'(mag_s3_r[i]) << SH;
      // quotient of 2^33 or more saturates whatever its sign
      side_nxt.ovf[i] = (num >= lim);
      div_nxt.rem[i]  = NW'(num >> QB);
      div_nxt.nq[i]   = num[QB-1:0];
    end
  end

  qmi_side_t         side_r [QB+1];
  qmi_pkg::qmi_div_t div_r;

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_nxt;
      div_r     <= div_nxt;
      for (int k = 1; k <= QB; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  // stages 5..37: divider
  logic [3:0][QB-1:0] q_c;

  qmi_div_pipe u_div (
    .clk   (clk),
    .en    (en),
    .div_i (div_r),
    .q_o   (q_c)
  );

  // output stage: round the quotient, apply sign, saturate, pick result
  logic [3:0][DW-1:0] res_nxt;
  logic               sat_nxt;

  always_comb begin
    logic [QB-1:0] qr;
    qmi_side_t     sd;
    sd      = side_r[QB];
    sat_nxt = 1'b0;
    for (int i = 0; i < 4; i++) begin
      qr = QB'(({1'b0, q_c[i]} + (QB+1)'(1)) >> 1);
      res_nxt[i] = '0;
      if (sd.op == qmi_pkg::OP_MUL) begin
        res_nxt[i] = sd.res[i];
      end else if (sd.zn) begin
        res_nxt[i] = '0;
      end else if (sd.ovf[i]) begin
        res_nxt[i] = sd.neg[i] ? MINV : MAXV;
        sat_nxt    = 1'b1;
      end else if (sd.neg[i]) begin
        if (qr > HALF_Q) begin
          res_nxt[i] = MINV;
          sat_nxt    = 1'b1;
        end else begin
          res_nxt[i] = DW'(~qr + QB'(1));
        end
      end else begin
        if (qr >= HALF_Q) begin
          res_nxt[i] = MAXV;
          sat_nxt    = 1'b1;
        end else begin
          res_nxt[i] = qr[DW-1:0];
        end
      end
    end
    if (sd.op == qmi_pkg::OP_MUL) begin
      sat_nxt = sd.sat;
    end
  end

  logic [3:0][DW-1:0] res_r;
  logic               sat_r;
  logic               zn_r;

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
      sat_r <= sat_nxt;
      zn_r  <= side_r[QB].zn;
    end
  end

  assign out_valid     = v_r[NS-1];
  assign out_res_w     = res_r[0];
  assign out_res_x     = res_r[1];
  assign out_res_y     = res_r[2];
  assign out_res_z     = res_r[3];
  assign out_saturated = sat_r;
  assign out_zero_norm = zn_r;

endmodule
`default_nettype wire

/* rtl/core/qmi_checker.sv */
// Port-level checker for the quaternion multiply / inverse core, with bind
`default_nettype none
`include "quaternion_multiply_inverse_core_defines.svh"
module qmi_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_res_w,
  input logic signed [31:0] out_res_x,
  input logic signed [31:0] out_res_y,
  input logic signed [31:0] out_res_z,
  input logic               out_saturated,
  input logic               out_zero_norm
);

  // a stalled item stays put: valid, res_w, res_z and saturated hold
  `QMI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_res_w) && $stable(out_res_z) && $stable(out_saturated), "stalled result changed")

  // input side opens whenever the output register can drain
  `QMI_ASSERT_IMPL(a_ready_link, clk, rst_n, 1'b1, in_ready == (!out_valid || out_ready), "in_ready does not follow output stall")

  // zero norm gives zeros and no clipping
  `QMI_ASSERT_IMPL(a_zero_norm, clk, rst_n, out_valid && out_zero_norm, out_res_w == 0 && out_res_x == 0 && out_res_y == 0 && out_res_z == 0 && !out_saturated, "zero-norm result not zero")

endmodule

bind quaternion_multiply_inverse_core qmi_checker u_qmi_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_res_w     (out_res_w),
  .out_res_x     (out_res_x),
  .out_res_y     (out_res_y),
  .out_res_z     (out_res_z),
  .out_saturated (out_saturated),
  .out_zero_norm (out_zero_norm)
);
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the quaternion multiply / inverse core
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  localparam int FRAC       = 24;
  localparam int LATENCY    = 37;
  localparam int N_RANDOM   = 1630;
  localparam int CYCLE_MAX  = 400000;

  localparam qmi_pkg::qmi_op_t OP_MUL = qmi_pkg::OP_MUL;
  localparam qmi_pkg::qmi_op_t OP_INV = qmi_pkg::OP_INV;

  typedef struct packed {
    qmi_pkg::qmi_op_t   op;
    logic signed [31:0] aw, ax, ay, az, bw, bx, by, bz;
  } quat_req_t;

  typedef struct packed {
    logic signed [31:0] w, x, y, z;
    logic               sat, zn;
  } quat_res_t;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic in_opcode;
  logic signed [31:0] in_a_w, in_a_x, in_a_y, in_a_z, in_b_w, in_b_x, in_b_y, in_b_z;
  logic signed [31:0] out_res_w, out_res_x, out_res_y, out_res_z;
  logic out_saturated, out_zero_norm;

  quat_req_t pending_items[$];
  quat_res_t expected_results[$];
  int        n_errors = 0;
  int        n_mul = 0, n_inv = 0, n_zero = 0, n_sat = 0, n_checked = 0;
  int        cycle_count = 0;
  bit        hold_input = 0;
  int        long_stall_req = 0;

  quaternion_multiply_inverse_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_opcode(in_opcode),
    .in_a_w(in_a_w), .in_a_x(in_a_x), .in_a_y(in_a_y), .in_a_z(in_a_z),
    .in_b_w(in_b_w), .in_b_x(in_b_x), .in_b_y(in_b_y), .in_b_z(in_b_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_res_w(out_res_w), .out_res_x(out_res_x), .out_res_y(out_res_y),
    .out_res_z(out_res_z), .out_saturated(out_saturated), .out_zero_norm(out_zero_norm)
  );

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // clip to 32 bits, note clipping
  function automatic logic signed [31:0] clip32(logic signed [127:0] v, inout logic s);
    if (v > 128'sd2147483647) begin
      s = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      s = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // exact four-term sum rounded to FRAC bits, ties toward plus infinity
  function automatic logic signed [127:0] round_sum(logic signed [127:0] s);
    logic signed [127:0] t;
    t = s + (128'sd1 <<< (FRAC - 1));
    return t >>> FRAC;
  endfunction

  // |c| * 2^(2*FRAC) / norm, nearest with ties away from zero
  function automatic logic signed [127:0] inv_comp(logic signed [127:0] c,
                                                   logic [127:0] norm);
    logic [127:0] mag, num, q;
    mag = (c < 0) ? -c : c;
    num = (mag << (2 * FRAC + 1)) / norm;
    q = (num + 1) >> 1;
    return (c < 0) ? -$signed(q) : $signed(q);
  endfunction

  function automatic quat_res_t hamilton_or_inverse(quat_req_t r);
    quat_res_t o;
    logic signed [127:0] aw, ax, ay, az, bw, bx, by, bz, v[4];
    logic [127:0] norm;
    logic s;
    s = 1'b0;
    aw = r.aw; ax = r.ax; ay = r.ay; az = r.az;
    bw = r.bw; bx = r.bx; by = r.by; bz = r.bz;
    o.zn = 1'b0;
    if (r.op == OP_MUL) begin
      v[0] = round_sum(aw*bw - ax*bx - ay*by - az*bz);
      v[1] = round_sum(aw*bx + ax*bw + ay*bz - az*by);
      v[2] = round_sum(aw*by + ay*bw - ax*bz + az*bx);
      v[3] = round_sum(aw*bz + az*bw + ax*by - ay*bx);
    end else begin
      norm = aw*aw + ax*ax + ay*ay + az*az;
      if (norm == 0) begin
        o.zn = 1'b1;
        for (int i = 0; i < 4; i++) v[i] = 0;
      end else begin
        v[0] = inv_comp(aw, norm);
        v[1] = inv_comp(-ax, norm);
        v[2] = inv_comp(-ay, norm);
        v[3] = inv_comp(-az, norm);
      end
    end
    o.w = clip32(v[0], s);
    o.x = clip32(v[1], s);
    o.y = clip32(v[2], s);
    o.z = clip32(v[3], s);
    o.sat = s;
    return o;
  endfunction

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'h01000000 : 32'hff000000;
      3: return 32'($signed($urandom_range(0, 2047)) - 1024);
      4: return 32'($signed($urandom_range(0, 32'h03ffffff)) - 32'sh02000000);
      default: return 32'd0;
    endcase
  endfunction

  function automatic quat_req_t rand_item();
    quat_req_t r;
    r.op = qmi_pkg::qmi_op_t'($urandom_range(0, 1));
    r.aw = rand_comp(); r.ax = rand_comp(); r.ay = rand_comp(); r.az = rand_comp();
    r.bw = rand_comp(); r.bx = rand_comp(); r.by = rand_comp(); r.bz = rand_comp();
    return r;
  endfunction

  function automatic quat_req_t mk(qmi_pkg::qmi_op_t op, logic [31:0] c0, logic [31:0] c1,
                                   logic [31:0] c2, logic [31:0] c3, logic [31:0] d0,
                                   logic [31:0] d1, logic [31:0] d2, logic [31:0] d3);
    quat_req_t r;
    r.op = op; r.aw = c0; r.ax = c1; r.ay = c2; r.az = c3;
    r.bw = d0; r.bx = d1; r.by = d2; r.bz = d3;
    return r;
  endfunction

  // stimulus
  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // directed: units, extremes, zero norm, exact 2^64 norm, ties, all bits
    pending_items.push_back(mk(OP_MUL, 32'h01000000, 0, 0, 0, 32'h01000000, 0, 0, 0));
    pending_items.push_back(mk(OP_MUL, 0, 32'h01000000, 0, 0, 0, 32'h01000000, 0, 0));
    pending_items.push_back(mk(OP_MUL, 0, 0, 32'h01000000, 0, 0, 0, 0, 32'h01000000));
    pending_items.push_back(mk(OP_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               32'h7fffffff));
    pending_items.push_back(mk(OP_MUL, 32'h80000000, 32'h80000000, 32'h80000000,
                               32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                               32'h80000000));
    pending_items.push_back(mk(OP_MUL, 32'h80000000, 32'h7fffffff, 32'h80000000,
                               32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000,
                               32'h7fffffff));
    pending_items.push_back(mk(OP_MUL, 32'h00800000, 0, 0, 0, 1, 0, 0, 0));
    pending_items.push_back(mk(OP_MUL, 32'hff800000, 0, 0, 0, 1, 0, 0, 0));
    pending_items.push_back(mk(OP_MUL, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                               32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                               32'hffffffff));
    pending_items.push_back(mk(OP_MUL, 0, 0, 0, 0, 32'h12345678, 32'h9abcdef0, 1, 2));
    pending_items.push_back(mk(OP_INV, 0, 0, 0, 0, 32'hffffffff, 32'h5a5a5a5a, 0, 1));
    pending_items.push_back(mk(OP_INV, 32'h01000000, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_INV, 0, 32'hff000000, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_INV, 1, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_INV, 0, 0, 0, 32'hffffffff, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_INV, 32'h80000000, 32'h80000000, 32'h80000000,
                               32'h80000000, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_INV, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               32'h7fffffff, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_INV, 32'h80000000, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_INV, 3, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(mk(OP_INV, 0, 0, 32'hfffffffd, 0, 0, 0, 0, 0));
    // random, first half
    for (int i = 0; i < N_RANDOM / 2; i++) pending_items.push_back(rand_item());
    // long receiver hold-off while the sender keeps offering
    wait (pending_items.size() < N_RANDOM / 2 - 40);
    long_stall_req = 300;
    // let everything drain before the next batch
    wait (pending_items.size() == 0);
    hold_input = 1'b1;
    for (int i = 0; i < N_RANDOM - N_RANDOM / 2; i++) pending_items.push_back(rand_item());
    wait (expected_results.size() == 0);
    @(posedge clk);
    hold_input <= 1'b0;
    wait (pending_items.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (LATENCY + 5) @(posedge clk);
    $display("covered %0d multiplies and %0d inverses, %0d zero-norm, %0d saturated,",
             n_mul, n_inv, n_zero, n_sat);
    $display("%0d results checked under bursty input and stalled output", n_checked);
    if (n_errors == 0 && expected_results.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  // driver: bursts and gaps
  int burst_left = 0, gap_left = 0;
  always @(posedge clk) begin
    quat_req_t r;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_opcode <= 1'b0;
      {in_a_w, in_a_x, in_a_y, in_a_z, in_b_w, in_b_x, in_b_y, in_b_z} <= '0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        r.op = qmi_pkg::qmi_op_t'(in_opcode);
        r.aw = in_a_w; r.ax = in_a_x; r.ay = in_a_y; r.az = in_a_z;
        r.bw = in_b_w; r.bx = in_b_x; r.by = in_b_y; r.bz = in_b_z;
        expected_results.push_back(hamilton_or_inverse(r));
        if (r.op == OP_MUL) n_mul++; else n_inv++;
      end
      if (gap_left > 0) gap_left--;
      if (!hold_input && gap_left == 0 && pending_items.size() > 0) begin
        r = pending_items.pop_front();
        in_valid <= 1'b1;
        in_opcode <= r.op;
        in_a_w <= r.aw; in_a_x <= r.ax; in_a_y <= r.ay; in_a_z <= r.az;
        in_b_w <= r.bw; in_b_x <= r.bx; in_b_y <= r.by; in_b_z <= r.bz;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern, plus one long hold-off
  int stall_phase = 0, long_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      stall_phase = (stall_phase + 1) % 64;
      if (long_stall_req > 0 && long_left == 0) begin
        long_left = long_stall_req;
        long_stall_req = 0;
      end
      if (long_left > 0) begin
        long_left--;
        out_ready <= 1'b0;
      end else if (stall_phase < 20) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  // monitor and checker
  always @(posedge clk) begin
    quat_res_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result w=%h", $time, out_res_w);
        n_errors++;
      end else begin
        e = expected_results.pop_front();
        n_checked++;
        if (e.zn) n_zero++;
        if (e.sat) n_sat++;
        if (out_res_w !== e.w) begin
          $display("%0t: res_w exp %h got %h", $time, e.w, out_res_w); n_errors++;
        end
        if (out_res_x !== e.x) begin
          $display("%0t: res_x exp %h got %h", $time, e.x, out_res_x); n_errors++;
        end
        if (out_res_y !== e.y) begin
          $display("%0t: res_y exp %h got %h", $time, e.y, out_res_y); n_errors++;
        end
        if (out_res_z !== e.z) begin
          $display("%0t: res_z exp %h got %h", $time, e.z, out_res_z); n_errors++;
        end
        if (out_saturated !== e.sat) begin
          $display("%0t: saturated exp %b got %b", $time, e.sat, out_saturated);
          n_errors++;
        end
        if (out_zero_norm !== e.zn) begin
          $display("%0t: zero_norm exp %b got %b", $time, e.zn, out_zero_norm);
          n_errors++;
        end
      end
    end
  end

  // timeout
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_MAX) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+rtl/core
rtl/core/qmi_pkg.sv
rtl/core/qmi_div_pipe.sv
rtl/core/quaternion_multiply_inverse_core.sv
rtl/core/qmi_checker.sv
dv/tb_top.sv
